// ===== rtl/psfu_pkg.sv =====
// shared types, codes and series tables for the power series function unit
// no dependencies; used via scoped names by all modules but the checker
`default_nettype none

package psfu_pkg;

  localparam int OP_W   = 40;
  localparam int VAL_W  = 48;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int MAG_W  = 64;
  localparam int DIV_W  = 10;
  localparam int N_W    = 5;
  localparam int ACC_W  = 65;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STAT_W-1:0] stat_code_t;

  localparam kind_t KIND_SIN  = 3'd0;
  localparam kind_t KIND_COS  = 3'd1;
  localparam kind_t KIND_EXP  = 3'd2;
  localparam kind_t KIND_LN   = 3'd3;
  localparam kind_t KIND_ATAN = 3'd4;

  localparam stat_code_t ST_OK  = 2'd0;
  localparam stat_code_t ST_DOM = 2'd1;
  localparam stat_code_t ST_SAT = 2'd2;

  localparam logic [MAG_W-1:0] GUARD_T = 64'd1 << 58;
  localparam logic signed [ACC_W-1:0] GUARD_S = 65'sd1 <<< 62;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LNDIV, S_SQGO, S_SQ, S_TERM,
    S_MUL, S_DIV, S_ADD, S_NEXT, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic ln_step;
    logic ln_fin;
    logic sq_start;
    logic sq_save;
    logic t0_start;
    logic tm_start;
    logic mul_take;
    logic set_ovf;
    logic add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic is_ln;
    logic is_exp;
    logic ln_done;
    logic mul_done;
    logic mul_guard;
    logic div_done;
    logic n_zero;
    logic fin;
  } stat_t;

  // divisor applied to term n
  function automatic logic [DIV_W-1:0] div_of(input kind_t kind, input logic [N_W-1:0] n);
    logic [DIV_W-1:0] n2;
    logic [DIV_W-1:0] d;
    n2 = DIV_W'(n) << 1;
    if (n == '0) begin
      d = DIV_W'(1);
    end else begin
      case (kind)
        KIND_SIN: d = DIV_W'(n2 * (n2 + DIV_W'(1)));
        KIND_COS: d = DIV_W'((n2 - DIV_W'(1)) * n2);
        KIND_EXP: d = DIV_W'(n);
        default:  d = n2 + DIV_W'(1);
      endcase
    end
    return d;
  endfunction

  function automatic logic last_of(input kind_t kind, input logic [N_W-1:0] n);
    logic l;
    case (kind)
      KIND_SIN, KIND_COS: l = (n == N_W'(11));
      KIND_EXP:           l = (n == N_W'(14));
      KIND_LN:            l = (n == N_W'(24));
      default:            l = (n == N_W'(19));
    endcase
    return l;
  endfunction

  function automatic logic term_neg(input kind_t kind, input logic neg,
                                    input logic lnneg, input logic odd);
    logic s;
    case (kind)
      KIND_SIN, KIND_ATAN: s = neg ^ odd;
      KIND_COS:            s = odd;
      KIND_EXP:            s = neg & odd;
      default:             s = lnneg;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/psfu_mul.sv =====
// 64x64 multiply with fraction shift, built from one 32x32 multiplier over four beats
// depends on psfu_pkg
`default_nettype none

module psfu_mul #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [psfu_pkg::MAG_W-1:0]  a,
  input  wire logic [psfu_pkg::MAG_W-1:0]  b,
  output logic      [psfu_pkg::MAG_W-1:0]  res,
  output logic                             sat,
  output logic                             done
);

  logic [63:0]  a_r, b_r;
  logic [1:0]   k_r;
  logic         busy_r;
  logic [63:0]  pp_r;
  logic [1:0]   pk_r;
  logic         pv_r;
  logic [127:0] acc_r;
  logic         done_r;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_sh;
  logic [1:0]   pos;

  assign a_part = k_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_part = k_r[1] ? b_r[63:32] : b_r[31:0];
  assign pos    = 2'(pk_r[0]) + 2'(pk_r[1]);

  always_comb begin
    case (pos)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 2'd0;
    end else begin
      pv_r   <= busy_r;
      done_r <= pv_r && (pk_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= 2'd0;
      end else if (busy_r) begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + pp_sh;
    end
    pp_r <= a_part * b_part;
    pk_r <= k_r;
  end

  assign res  = acc_r[FRAC_BITS +: 64];
  assign sat  = |acc_r[127:64+FRAC_BITS];
  assign done = done_r;

endmodule

`default_nettype wire

// ===== rtl/psfu_dp.sv =====
// datapath: operand decode, ln pre-division, term chain, small divider, accumulator, output regs
// depends on psfu_pkg and psfu_mul
`default_nettype none

module psfu_dp #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire psfu_pkg::cmd_t               cmd,
  output psfu_pkg::stat_t                   stat,
  input  wire psfu_pkg::kind_t              in_kind,
  input  wire logic [psfu_pkg::OP_W-1:0]    in_operand,
  output logic [psfu_pkg::VAL_W-1:0]        out_value,
  output psfu_pkg::stat_code_t              out_status
);

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int LW = psfu_pkg::OP_W + 2;
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic signed [67:0] OUT_MAX = (68'sd1 <<< 47) - 68'sd1;
  localparam logic signed [67:0] OUT_MIN = -(68'sd1 <<< 47);

  psfu_pkg::kind_t            kind_r;
  logic [psfu_pkg::OP_W-1:0]  raw_r, mag_r;
  logic                       neg_r, lnneg_r;
  logic [63:0]                base_r, m_r, sq_r;
  logic signed [psfu_pkg::ACC_W-1:0] acc_r;
  logic [psfu_pkg::N_W-1:0]   n_r;
  logic                       ovf_r, fin_r;
  logic [LW-1:0]              lr_r, lb_r;
  logic [63:0]                lq_r;
  logic [CW-1:0]              lc_r;
  logic [63:0]                dv_r, dq_r;
  logic [psfu_pkg::DIV_W-1:0] dd_r, drem_r;
  logic [2:0]                 dc_r;
  logic                       dbusy_r, ddone_r;
  logic [psfu_pkg::VAL_W-1:0] val_r;
  psfu_pkg::stat_code_t       sta_r;

  logic [psfu_pkg::OP_W-1:0]  in_mag;
  logic                       in_neg;
  logic [LW-1:0]              lr2;
  logic                       mul_start, mul_sat, mul_done;
  logic [63:0]                mul_a, mul_b, mul_res;
  logic [psfu_pkg::DIV_W-1:0] rem;
  logic [7:0]                 qbits;
  logic [psfu_pkg::DIV_W:0]   t;
  logic                       type1, tneg, q_big, sum_ovf;
  logic signed [psfu_pkg::ACC_W-1:0] sum;
  logic signed [67:0]         tot;
  logic                       lead_neg, unused, domain;
  logic [psfu_pkg::VAL_W-1:0] val_nxt;
  psfu_pkg::stat_code_t       sta_nxt;

  assign in_neg = in_operand[psfu_pkg::OP_W-1];
  assign in_mag = in_neg ? (psfu_pkg::OP_W'(0) - in_operand) : in_operand;
  assign lr2    = lr_r << 1;

  assign mul_start = cmd.sq_start | cmd.tm_start;
  assign mul_a     = cmd.sq_start ? base_r : m_r;
  assign mul_b     = cmd.sq_start ? base_r : sq_r;

  psfu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mul_res),
    .sat   (mul_sat),
    .done  (mul_done)
  );

  // eight quotient bits per beat
  always_comb begin
    rem   = drem_r;
    qbits = '0;
    t     = '0;
    for (int i = 0; i < 8; i++) begin
      t = {rem, dv_r[63-i]};
      if (t >= {1'b0, dd_r}) begin
        rem          = psfu_pkg::DIV_W'(t - {1'b0, dd_r});
        qbits[7-i]   = 1'b1;
      end else begin
        rem = t[psfu_pkg::DIV_W-1:0];
      end
    end
  end

  assign type1 = (kind_r == psfu_pkg::KIND_SIN) || (kind_r == psfu_pkg::KIND_COS) ||
                 (kind_r == psfu_pkg::KIND_EXP);
  assign tneg  = psfu_pkg::term_neg(kind_r, neg_r, lnneg_r, n_r[0]);
  assign q_big = dq_r >= psfu_pkg::GUARD_T;
  assign sum   = tneg ? (acc_r - $signed({1'b0, dq_r})) : (acc_r + $signed({1'b0, dq_r}));
  assign sum_ovf = (sum > psfu_pkg::GUARD_S) || (sum < -psfu_pkg::GUARD_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      ddone_r <= dbusy_r && (dc_r == 3'd7);
      if (cmd.t0_start || cmd.mul_take) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && (dc_r == 3'd7)) begin
        dbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      raw_r   <= in_operand;
      neg_r   <= in_neg;
      mag_r   <= in_mag;
      lnneg_r <= {24'd0, in_operand} < ONE;
    end
    if (cmd.init) begin
      base_r <= 64'(mag_r);
      m_r    <= ((kind_r == psfu_pkg::KIND_COS) || (kind_r == psfu_pkg::KIND_EXP)) ?
                ONE : 64'(mag_r);
      sq_r   <= 64'(mag_r);
      acc_r  <= '0;
      n_r    <= '0;
      ovf_r  <= 1'b0;
      fin_r  <= 1'b0;
      lb_r   <= LW'(raw_r) + LW'(ONE);
      lr_r   <= lnneg_r ? (LW'(ONE) - LW'(raw_r)) : (LW'(raw_r) - LW'(ONE));
      lq_r   <= '0;
      lc_r   <= '0;
    end
    if (cmd.ln_step) begin
      lc_r <= lc_r + CW'(1);
      if (lr2 >= lb_r) begin
        lr_r <= lr2 - lb_r;
        lq_r <= {lq_r[62:0], 1'b1};
      end else begin
        lr_r <= lr2;
        lq_r <= {lq_r[62:0], 1'b0};
      end
    end
    if (cmd.ln_fin) begin
      base_r <= lq_r;
      m_r    <= lq_r;
    end
    if (cmd.sq_save) begin
      sq_r <= mul_res;
    end
    if (cmd.t0_start) begin
      dv_r   <= m_r;
      dd_r   <= psfu_pkg::DIV_W'(1);
      drem_r <= '0;
      dc_r   <= '0;
    end else if (cmd.mul_take) begin
      dv_r   <= mul_res;
      dd_r   <= psfu_pkg::div_of(kind_r, n_r);
      drem_r <= '0;
      dc_r   <= '0;
      if (!type1) begin
        m_r <= mul_res;
      end
    end else if (dbusy_r) begin
      dv_r   <= dv_r << 8;
      dq_r   <= {dq_r[55:0], qbits};
      drem_r <= rem;
      dc_r   <= dc_r + 3'd1;
    end
    if (cmd.set_ovf) begin
      ovf_r <= 1'b1;
    end
    if (cmd.add) begin
      n_r   <= n_r + psfu_pkg::N_W'(1);
      fin_r <= psfu_pkg::last_of(kind_r, n_r);
      if (q_big) begin
        ovf_r <= 1'b1;
      end else begin
        acc_r <= sum;
        ovf_r <= sum_ovf;
      end
      if (type1) begin
        m_r <= dq_r;
      end
    end
    if (cmd.out_load) begin
      val_r <= val_nxt;
      sta_r <= sta_nxt;
    end
  end

  // final value
  assign unused = kind_r > psfu_pkg::KIND_ATAN;
  assign domain = (kind_r == psfu_pkg::KIND_LN) && (neg_r || (raw_r == '0));
  assign tot    = (kind_r == psfu_pkg::KIND_LN) ? (68'(acc_r) <<< 1) : 68'(acc_r);

  always_comb begin
    case (kind_r)
      psfu_pkg::KIND_SIN, psfu_pkg::KIND_ATAN: lead_neg = !neg_r;
      psfu_pkg::KIND_COS:                      lead_neg = 1'b1;
      default:                                 lead_neg = 1'b0;
    endcase
    if (unused) begin
      val_nxt = '0;
      sta_nxt = psfu_pkg::ST_OK;
    end else if (domain) begin
      val_nxt = '0;
      sta_nxt = psfu_pkg::ST_DOM;
    end else if (ovf_r) begin
      val_nxt = lead_neg ? psfu_pkg::VAL_W'(OUT_MIN) : psfu_pkg::VAL_W'(OUT_MAX);
      sta_nxt = psfu_pkg::ST_SAT;
    end else if (tot > OUT_MAX) begin
      val_nxt = psfu_pkg::VAL_W'(OUT_MAX);
      sta_nxt = psfu_pkg::ST_SAT;
    end else if (tot < OUT_MIN) begin
      val_nxt = psfu_pkg::VAL_W'(OUT_MIN);
      sta_nxt = psfu_pkg::ST_SAT;
    end else begin
      val_nxt = tot[psfu_pkg::VAL_W-1:0];
      sta_nxt = psfu_pkg::ST_OK;
    end
  end

  assign stat.special   = unused || domain;
  assign stat.is_ln     = kind_r == psfu_pkg::KIND_LN;
  assign stat.is_exp    = kind_r == psfu_pkg::KIND_EXP;
  assign stat.ln_done   = lc_r == CW'(FRAC_BITS);
  assign stat.mul_done  = mul_done;
  assign stat.mul_guard = mul_sat || (mul_res >= psfu_pkg::GUARD_T);
  assign stat.div_done  = ddone_r;
  assign stat.n_zero    = n_r == '0;
  assign stat.fin       = fin_r || ovf_r;

  assign out_value  = val_r;
  assign out_status = sta_r;

endmodule

`default_nettype wire

// ===== rtl/psfu_ctrl.sv =====
// sequencer: runs decode, ln pre-division, squaring, term loop and output
// depends on psfu_pkg
`default_nettype none

module psfu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire psfu_pkg::stat_t  stat,
  output psfu_pkg::cmd_t        cmd
);

  psfu_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psfu_pkg::S_IDLE:   if (in_tvalid) state_nxt = psfu_pkg::S_DECODE;
      psfu_pkg::S_DECODE: begin
        if (stat.special)     state_nxt = psfu_pkg::S_DONE;
        else if (stat.is_ln)  state_nxt = psfu_pkg::S_LNDIV;
        else if (stat.is_exp) state_nxt = psfu_pkg::S_TERM;
        else                  state_nxt = psfu_pkg::S_SQGO;
      end
      psfu_pkg::S_LNDIV:  if (stat.ln_done) state_nxt = psfu_pkg::S_SQGO;
      psfu_pkg::S_SQGO:   state_nxt = psfu_pkg::S_SQ;
      psfu_pkg::S_SQ:     if (stat.mul_done) state_nxt = psfu_pkg::S_TERM;
      psfu_pkg::S_TERM:   state_nxt = stat.n_zero ? psfu_pkg::S_DIV : psfu_pkg::S_MUL;
      psfu_pkg::S_MUL: begin
        if (stat.mul_done) begin
          state_nxt = stat.mul_guard ? psfu_pkg::S_DONE : psfu_pkg::S_DIV;
        end
      end
      psfu_pkg::S_DIV:    if (stat.div_done) state_nxt = psfu_pkg::S_ADD;
      psfu_pkg::S_ADD:    state_nxt = psfu_pkg::S_NEXT;
      psfu_pkg::S_NEXT:   state_nxt = stat.fin ? psfu_pkg::S_DONE : psfu_pkg::S_TERM;
      psfu_pkg::S_DONE:   if (!out_valid_r || out_tready) state_nxt = psfu_pkg::S_IDLE;
      default:            state_nxt = psfu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      psfu_pkg::S_IDLE:   cmd.load = in_tvalid;
      psfu_pkg::S_DECODE: cmd.init = 1'b1;
      psfu_pkg::S_LNDIV: begin
        cmd.ln_step = !stat.ln_done;
        cmd.ln_fin  = stat.ln_done;
      end
      psfu_pkg::S_SQGO:   cmd.sq_start = 1'b1;
      psfu_pkg::S_SQ:     cmd.sq_save = stat.mul_done;
      psfu_pkg::S_TERM: begin
        cmd.t0_start = stat.n_zero;
        cmd.tm_start = !stat.n_zero;
      end
      psfu_pkg::S_MUL: begin
        cmd.mul_take = stat.mul_done && !stat.mul_guard;
        cmd.set_ovf  = stat.mul_done && stat.mul_guard;
      end
      psfu_pkg::S_ADD:    cmd.add = 1'b1;
      psfu_pkg::S_DONE:   cmd.out_load = !out_valid_r || out_tready;
      default:            cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psfu_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == psfu_pkg::S_IDLE;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/power_series_function_unit.sv =====
// power series function unit: sine, cosine, exp, ln and arctan by truncated series
// top level; depends on psfu_pkg, psfu_ctrl, psfu_dp, psfu_mul
//
// usage
//   input beat: in_tuser carries the function code, in_tdata the Q8.32 operand
//   output beat: out_tdata carries the Q16.32 value, out_tuser the status code
//   one item is worked on at a time; in_tready is high only while the unit is free
//   every further term costs a start step, the shared 32x32 multiplier,
//   the radix-256 constant divider and the accumulate step
//   from the accepting edge to out_tvalid: decode, squaring, the first term,
//   each further term and the output load; exp skips the squaring and
//   ln adds its pre-division; a series that overflows ends early
//   unused codes and ln domain errors go from decode straight to the output load
//   the next beat can be taken in the cycle after a result is loaded
//   the output register holds one finished result; a new beat is taken while it
//   waits, and the next result stalls in the sequencer until the receiver takes it
//   reset clears the sequencer and the output valid flag; no clearing pass needed
`default_nettype none

module power_series_function_unit #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // operand[39:0]
  input  wire logic [2:0]  in_tuser,   // kind[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // value[47:0]
  output logic [1:0]       out_tuser   // status[1:0]
);

  psfu_pkg::cmd_t  cmd;
  psfu_pkg::stat_t stat;

  psfu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  psfu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (in_tuser),
    .in_operand (in_tdata),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/psfu_checker.sv =====
// port-level checks for the power series function unit, bound to the top level
// depends on power_series_function_unit ports only
`default_nettype none

module psfu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined status");

  a_dom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'd1 |-> out_tdata == 48'd0)
    else $error("domain error with nonzero value");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'd2 |->
      out_tdata == 48'h7FFF_FFFF_FFFF || out_tdata == 48'h8000_0000_0000)
    else $error("saturated value off the rails");

endmodule

bind power_series_function_unit psfu_checker u_psfu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
